>>> rtl/layered_rect_draw_engine_top_macros.svh
// Assertion helpers used by the RTL controller (lrde_ctrl).
// Both sample on clk and are disabled while rst_n is low.
`ifndef LAYERED_RECT_DRAW_ENGINE_TOP_MACROS_SVH
`define LAYERED_RECT_DRAW_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define LRDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LRDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lrde_pkg.sv
`default_nettype none

package lrde_pkg;

    // default geometry
    localparam int NUM_COLS_DEF     = 8;
    localparam int NUM_ROWS_DEF     = 8;
    localparam int NUM_LAYERS_DEF   = 4;
    localparam int CHANNEL_BITS_DEF = 8;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int LAYER_W = 2;
    localparam int COORD_W = 3;
    localparam int POS_W   = COORD_W + 1;  // coordinate plus offset, up to 14
    localparam int COLOR_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [LAYER_W-1:0] layer;
        logic [COORD_W-1:0] rect_col;
        logic [COORD_W-1:0] rect_row;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic               fill;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } request_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_red;
        logic [COLOR_W-1:0] pixel_green;
        logic [COLOR_W-1:0] pixel_blue;
        logic               clipped;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, reset scan and clear counters
        logic draw_step;  // visit one rectangle pixel
        logic clr_step;   // zero one store entry
        logic emit;       // load result register, strobe done
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;  // current pixel is the rectangle's last
        logic clr_last;   // current entry is the store's last
    } ctrl_sts_t;

endpackage

`default_nettype wire

>>> rtl/lrde_ram.sv
`default_nettype none

module lrde_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/lrde_ctrl.sv
`default_nettype none

module lrde_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [lrde_pkg::CMD_W-1:0]        command,
    input  wire lrde_pkg::ctrl_sts_t               sts,
    output lrde_pkg::ctrl_cmd_t                    cmd,
    output logic                                   busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   clr_req_reg, clr_req_next;  // clear was requested, so it owes a result
    logic   accept;
    logic [3:0] cmd_bits;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_req_next = clr_req_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    unique case (command)
                        lrde_pkg::CMD_DRAW:  state_next = S_DRAW;
                        lrde_pkg::CMD_READ:  state_next = S_READ;
                        lrde_pkg::CMD_CLEAR:
                        begin
                            state_next   = S_CLEAR;
                            clr_req_next = 1'b1;
                        end
                        default:             state_next = S_EMIT;
                    endcase
                end
            end
            S_DRAW:
            begin
                cmd.draw_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            // address presented here, data valid in S_EMIT
            S_READ:  state_next = S_EMIT;
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next   = clr_req_reg ? S_EMIT : S_IDLE;
                    clr_req_next = 1'b0;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // reset enters the clearing pass over the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            busy_reg    <= 1'b1;
            clr_req_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            clr_req_reg <= clr_req_next;
        end
    end

    assign cmd_bits = {cmd.load, cmd.draw_step, cmd.clr_step, cmd.emit};

`include "layered_rect_draw_engine_top_macros.svh"

    `LRDE_ASSERT_NEXT(a_accept_busy, accept, busy_reg, "busy not raised after a request")
    `LRDE_ASSERT_NEXT(a_emit_idle, cmd.emit, !busy_reg, "busy still high after result")
    `LRDE_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd_bits), "overlapping datapath commands")
    `LRDE_ASSERT_NOW(a_load_idle, cmd.load, !busy_reg, "request loaded while busy")

endmodule

`default_nettype wire

>>> rtl/lrde_datapath.sv
`default_nettype none

module lrde_datapath #(
    parameter int NUM_COLS     = lrde_pkg::NUM_COLS_DEF,
    parameter int NUM_ROWS     = lrde_pkg::NUM_ROWS_DEF,
    parameter int NUM_LAYERS   = lrde_pkg::NUM_LAYERS_DEF,
    parameter int CHANNEL_BITS = lrde_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lrde_pkg::request_t   request,
    input  wire lrde_pkg::ctrl_cmd_t  cmd,
    output lrde_pkg::ctrl_sts_t       sts,
    output lrde_pkg::result_t         result,
    output logic                      done
);

    localparam int LAYER_PIX = NUM_COLS * NUM_ROWS;
    localparam int DEPTH     = NUM_LAYERS * LAYER_PIX;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PIX_W     = 3 * CHANNEL_BITS;
    localparam int POS_W     = lrde_pkg::POS_W;

    // request payload, held for the whole operation
    logic [lrde_pkg::CMD_W-1:0]   cmd_reg;
    logic [lrde_pkg::LAYER_W-1:0] lay_reg;
    logic [POS_W-1:0]             c0_reg, r0_reg, c_end_reg, r_end_reg;
    logic                         fill_reg;
    logic [PIX_W-1:0]             color_reg;
    lrde_pkg::result_t            result_reg, result_next;

    // control state
    logic [POS_W-1:0]  cur_c_reg, cur_c_next, cur_r_reg, cur_r_next;
    logic              clip_reg, clip_next;
    logic              lay_bad_reg, lay_bad_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              done_reg;

    logic              in_field, on_edge, paint, rd_ok, row_wrap;
    logic [ADDR_W-1:0] pix_addr, ram_addr;
    logic              ram_we;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;

    assign in_field = (int'(cur_c_reg) < NUM_COLS) && (int'(cur_r_reg) < NUM_ROWS);
    assign on_edge  = (cur_c_reg == c0_reg) || (cur_c_reg == c_end_reg) ||
                      (cur_r_reg == r0_reg) || (cur_r_reg == r_end_reg);
    assign paint    = on_edge || fill_reg;
    assign rd_ok    = !lay_bad_reg && in_field;
    assign row_wrap = (cur_r_reg == r_end_reg);

    // layer-major, then column, then row; wraps harmlessly when out of field
    assign pix_addr = ADDR_W'(lay_reg) * ADDR_W'(LAYER_PIX)
                    + ADDR_W'(cur_c_reg) * ADDR_W'(NUM_ROWS)
                    + ADDR_W'(cur_r_reg);

    assign sts.scan_last = (cur_c_reg == c_end_reg) && row_wrap;
    assign sts.clr_last  = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    assign ram_we    = cmd.clr_step || (cmd.draw_step && paint && in_field && !lay_bad_reg);
    assign ram_addr  = cmd.clr_step ? clr_cnt_reg : pix_addr;
    assign ram_wdata = cmd.clr_step ? '0 : color_reg;

    lrde_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cur_c_next   = cur_c_reg;
        cur_r_next   = cur_r_reg;
        clip_next    = clip_reg;
        lay_bad_next = lay_bad_reg;
        clr_cnt_next = clr_cnt_reg;
        if (cmd.load)
        begin
            cur_c_next   = POS_W'(request.rect_col);
            cur_r_next   = POS_W'(request.rect_row);
            clip_next    = 1'b0;
            lay_bad_next = (int'(request.layer) >= NUM_LAYERS);
            clr_cnt_next = '0;
        end
        if (cmd.draw_step)
        begin
            if (paint && !in_field)
            begin
                clip_next = 1'b1;
            end
            if (row_wrap)
            begin
                cur_r_next = r0_reg;
                cur_c_next = cur_c_reg + POS_W'(1);
            end
            else
            begin
                cur_r_next = cur_r_reg + POS_W'(1);
            end
        end
        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        result_next = '0;
        case (cmd_reg)
            lrde_pkg::CMD_DRAW:
            begin
                result_next.clipped = clip_reg || lay_bad_reg;
            end
            lrde_pkg::CMD_READ:
            begin
                result_next.clipped = !rd_ok;
                if (rd_ok)
                begin
                    result_next.pixel_red   = lrde_pkg::COLOR_W'(
                        ram_rdata[PIX_W-1 -: CHANNEL_BITS]);
                    result_next.pixel_green = lrde_pkg::COLOR_W'(
                        ram_rdata[2*CHANNEL_BITS-1 -: CHANNEL_BITS]);
                    result_next.pixel_blue  = lrde_pkg::COLOR_W'(
                        ram_rdata[CHANNEL_BITS-1:0]);
                end
            end
            default: result_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_c_reg   <= '0;
            cur_r_reg   <= '0;
            clip_reg    <= 1'b0;
            lay_bad_reg <= 1'b0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cur_c_reg   <= cur_c_next;
            cur_r_reg   <= cur_r_next;
            clip_reg    <= clip_next;
            lay_bad_reg <= lay_bad_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= request.command;
            lay_reg   <= request.layer;
            c0_reg    <= POS_W'(request.rect_col);
            r0_reg    <= POS_W'(request.rect_row);
            c_end_reg <= POS_W'(request.rect_col) + POS_W'(request.rect_width);
            r_end_reg <= POS_W'(request.rect_row) + POS_W'(request.rect_height);
            fill_reg  <= request.fill;
            color_reg <= {CHANNEL_BITS'(request.red), CHANNEL_BITS'(request.green),
                          CHANNEL_BITS'(request.blue)};
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> rtl/layered_rect_draw_engine_top.sv
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+-------------------------------------
// request  | start, busy, request           | taken at clk edge with start && !busy
// result   | done, result                   | valid for the one cycle done is high
//
// Sequence from request to done (done rises as busy falls):
//   draw  : visits every rectangle pixel in turn, writing the painted in-field ones
//   read  : presents the store address, then the registered RAM read gives the result
//   clear : one entry zeroed per cycle over the whole store, then the result
//   unused command code : result only
// After reset the block runs the same clearing pass (busy high, no result). A new
// request can be taken in the done cycle.
// The receiver cannot stall: each result is shown once, for a single cycle.
`default_nettype none

module layered_rect_draw_engine_top #(
    parameter int NUM_COLS     = lrde_pkg::NUM_COLS_DEF,
    parameter int NUM_ROWS     = lrde_pkg::NUM_ROWS_DEF,
    parameter int NUM_LAYERS   = lrde_pkg::NUM_LAYERS_DEF,
    parameter int CHANNEL_BITS = lrde_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire lrde_pkg::request_t  request,
    output logic                     busy,
    output logic                     done,
    output lrde_pkg::result_t        result
);

    // controller <-> datapath
    lrde_pkg::ctrl_cmd_t cmd;
    lrde_pkg::ctrl_sts_t sts;

    // Sequencer: idle, draw scan, read, clearing pass, result emit.
    lrde_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    // Scan counters, clip tracking, frame store RAM and result register.
    lrde_datapath #(
        .NUM_COLS     (NUM_COLS),
        .NUM_ROWS     (NUM_ROWS),
        .NUM_LAYERS   (NUM_LAYERS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrde_pkg::*;

    // Fixed geometry of the instance under test (default parameters).
    localparam int COLS   = NUM_COLS_DEF;
    localparam int ROWS   = NUM_ROWS_DEF;
    localparam int LAYERS = NUM_LAYERS_DEF;
    localparam int REQ_W  = $bits(request_t);

    // Run length and watchdog. Worst legal request is a clear;
    // even if every request were a clear plus a long gap, the random
    // part would stay well inside this bound.
    localparam int RANDOM_REQUESTS = 1250;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES   = 300;

    // ------------------------------------------------------------------
    // Scoreboard: keeps a shadow copy of the layered frame store, predicts
    // the result of each accepted request and checks results in order.
    // ------------------------------------------------------------------
    class rect_scoreboard;
        result_t     expected_q[$];
        bit [23:0]   shadow_store [LAYERS][COLS][ROWS];
        int          errors;
        int          n_draw, n_draw_clipped, n_read, n_clear, n_unused;

        function int pending();
            return expected_q.size();
        endfunction

        // Update the shadow store for one accepted request and queue the
        // result the block should produce for it.
        function void note_request(request_t rq);
            result_t exp;
            int      c_end, r_end;
            bit      on_edge;
            exp = '0;
            case (rq.command)
                CMD_DRAW:
                begin
                    c_end = int'(rq.rect_col) + int'(rq.rect_width);
                    r_end = int'(rq.rect_row) + int'(rq.rect_height);
                    for (int c = rq.rect_col; c <= c_end; c++)
                    begin
                        for (int r = rq.rect_row; r <= r_end; r++)
                        begin
                            on_edge = (c == rq.rect_col) || (c == c_end) ||
                                      (r == rq.rect_row) || (r == r_end);
                            if (on_edge || rq.fill)
                            begin
                                // off-field pixels are dropped and flagged
                                if (c >= COLS || r >= ROWS)
                                    exp.clipped = 1'b1;
                                else
                                    shadow_store[rq.layer][c][r] =
                                        {rq.red, rq.green, rq.blue};
                            end
                        end
                    end
                    n_draw++;
                    if (exp.clipped)
                        n_draw_clipped++;
                end
                CMD_READ:
                begin
                    {exp.pixel_red, exp.pixel_green, exp.pixel_blue} =
                        shadow_store[rq.layer][rq.rect_col][rq.rect_row];
                    n_read++;
                end
                CMD_CLEAR:
                begin
                    foreach (shadow_store[l, c, r])
                        shadow_store[l][c][r] = '0;
                    n_clear++;
                end
                default:
                    n_unused++;
            endcase
            expected_q.insert(expected_q.size(), exp);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got %h", $time, got);
                return;
            end
            exp = expected_q.pop_front();
            compare_field("pixel_red", exp.pixel_red, got.pixel_red);
            compare_field("pixel_green", exp.pixel_green, got.pixel_green);
            compare_field("pixel_blue", exp.pixel_blue, got.pixel_blue);
            compare_field("clipped", 8'(exp.clipped), 8'(got.clipped));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    rect_scoreboard sb;
    int             cycle_count = 0;
    request_t       directed_q[$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    layered_rect_draw_engine_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, sb.pending());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Monitor: all signals are sampled at the edge with their pre-edge
    // values, since every driver (TB and RTL) updates with nonblocking
    // assignments. The result of an older request is checked before a
    // new request is noted; the FIFO keeps order either way.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // Present one request and hold it until the block takes it
    // (start high at an edge where busy is low).
    task automatic send_request(request_t rq);
        start   <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Random idle gap after a request: mostly none, some short, a few long.
    // The request bus carries junk while start is low; it must be ignored.
    task automatic idle_gap();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 55)
            n = 0;
        else if (pick < 90)
            n = $urandom_range(3, 1);
        else
            n = $urandom_range(40, 8);
        if (n > 0)
        begin
            start   <= 1'b0;
            request <= request_t'(REQ_W'({$urandom, $urandom}));
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold the sender off until every outstanding result has been seen.
    // It waits for a clock edge first so the request taken at this edge is already noted.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic void add_directed(request_t rq);
        directed_q.insert(directed_q.size(), rq);
    endfunction

    function automatic request_t make_req(logic [CMD_W-1:0] cmd, int lay, int col, int row,
                                          int w, int h, bit fill_en,
                                          logic [7:0] r, logic [7:0] g, logic [7:0] b);
        request_t rq;
        rq.command     = cmd;
        rq.layer       = LAYER_W'(lay);
        rq.rect_col    = COORD_W'(col);
        rq.rect_row    = COORD_W'(row);
        rq.rect_width  = COORD_W'(w);
        rq.rect_height = COORD_W'(h);
        rq.fill        = fill_en;
        rq.red         = r;
        rq.green       = g;
        rq.blue        = b;
        return rq;
    endfunction

    // Random mix: mostly draws and reads so the store fills up and reads
    // return painted pixels; clears are rare since they wipe everything.
    function automatic request_t random_request();
        request_t rq;
        int       pick;
        rq   = request_t'(REQ_W'({$urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 55)
            rq.command = CMD_DRAW;
        else if (pick < 90)
            rq.command = CMD_READ;
        else if (pick < 93)
            rq.command = CMD_CLEAR;
        else
            rq.command = CMD_NOP;
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new;

        // Hold reset low, then release it; the block then runs its clearing pass with
        // busy high, which the first request simply waits out.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        // store reads zero straight after reset
        add_directed(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        add_directed(make_req(CMD_READ, 3, 7, 7, 7, 7, 1, 8'hff, 8'hff, 8'hff));
        // full-layer filled draw, no clipping
        add_directed(make_req(CMD_DRAW, 0, 0, 0, 7, 7, 1, 8'hff, 8'hff, 8'hff));
        add_directed(make_req(CMD_READ, 0, 7, 7, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        add_directed(make_req(CMD_READ, 0, 3, 4, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        // far corner with maximum size: only one pixel lands, rest clipped
        add_directed(make_req(CMD_DRAW, 3, 7, 7, 7, 7, 0, 8'h12, 8'h34, 8'h56));
        add_directed(make_req(CMD_READ, 3, 7, 7, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        add_directed(make_req(CMD_READ, 3, 6, 7, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        // single-pixel draw
        add_directed(make_req(CMD_DRAW, 1, 3, 4, 0, 0, 0, 8'ha5, 8'h5a, 8'h3c));
        add_directed(make_req(CMD_READ, 1, 3, 4, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        // border only: interior stays, border painted
        add_directed(make_req(CMD_DRAW, 2, 1, 1, 5, 5, 0, 8'h80, 8'h01, 8'h7f));
        add_directed(make_req(CMD_READ, 2, 3, 3, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        add_directed(make_req(CMD_READ, 2, 1, 3, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        add_directed(make_req(CMD_READ, 2, 6, 6, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        // partly off the right edge, filled: on-field part painted
        add_directed(make_req(CMD_DRAW, 0, 5, 2, 4, 1, 1, 8'h00, 8'h00, 8'h00));
        add_directed(make_req(CMD_READ, 0, 7, 3, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        // partly off the bottom edge, border only
        add_directed(make_req(CMD_DRAW, 1, 0, 6, 2, 3, 0, 8'h0f, 8'hf0, 8'hcc));
        add_directed(make_req(CMD_READ, 1, 2, 7, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        // unused command code with every field at its top value
        add_directed(make_req(CMD_NOP, 3, 7, 7, 7, 7, 1, 8'hff, 8'hff, 8'hff));
        // clear wipes every layer
        add_directed(make_req(CMD_CLEAR, 3, 7, 7, 7, 7, 1, 8'hff, 8'hff, 8'hff));
        add_directed(make_req(CMD_READ, 0, 4, 4, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        add_directed(make_req(CMD_READ, 1, 3, 4, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        add_directed(make_req(CMD_READ, 3, 7, 7, 0, 0, 0, 8'h00, 8'h00, 8'h00));

        // directed requests go back to back, no gaps
        foreach (directed_q[i])
            send_request(directed_q[i]);
        drain_results();

        // Random part, with an occasional full drain of the result queue.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            send_request(random_request());
            if ($urandom_range(99) < 2)
                drain_results();
            else if (i % 200 < 150)
                idle_gap();
            // else: a stretch of back-to-back requests
        end

        // Wait out every outstanding result, then a little longer to catch
        // any stray strobe.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end

        $display("tb: %0d draws (%0d clipped), %0d reads, %0d clears, %0d unused-code requests",
                 sb.n_draw, sb.n_draw_clipped, sb.n_read, sb.n_clear, sb.n_unused);
        $display("tb: %0d mismatches in %0d cycles", sb.errors, cycle_count);

        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
